/* hdl/pcmf_pkg.sv */
// package: sample format codes, shared types and helper functions for pcm sample conversion
package pcmf_pkg;

  localparam int unsigned SampleW = 64;
  localparam int unsigned FloatW  = 32;
  localparam int unsigned FmtW    = 5;

  typedef enum logic [FmtW-1:0] {
    FMT_S8    = 5'd0,
    FMT_U8    = 5'd1,
    FMT_S16LE = 5'd2,
    FMT_S16BE = 5'd3,
    FMT_U16LE = 5'd4,
    FMT_U16BE = 5'd5,
    FMT_S24LE = 5'd6,
    FMT_S24BE = 5'd7,
    FMT_U24LE = 5'd8,
    FMT_U24BE = 5'd9,
    FMT_S32LE = 5'd10,
    FMT_S32BE = 5'd11,
    FMT_U32LE = 5'd12,
    FMT_U32BE = 5'd13,
    FMT_F32LE = 5'd14,
    FMT_F32BE = 5'd15,
    FMT_F64LE = 5'd16,
    FMT_F64BE = 5'd17
  } fmt_e;

  localparam logic [FmtW-1:0] FmtReset = FMT_S16LE;

  typedef enum logic [1:0] {
    KIND_INT  = 2'd0,
    KIND_F32  = 2'd1,
    KIND_F64  = 2'd2,
    KIND_ZERO = 2'd3
  } kind_e;

  // decoded stage-one beat
  typedef struct packed {
    kind_e       kind;
    logic        sign;
    logic [31:0] mag;
    logic [5:0]  bits_m1;
    logic [63:0] word;
  } prep_t;

  function automatic logic [63:0] bswap(input logic [63:0] x, input int unsigned n);
    logic [63:0] v;
    v = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < n) v[8*(n-1-i) +: 8] = x[8*i +: 8];
    end
    return v;
  endfunction

  function automatic logic [5:0] msb_pos(input logic [31:0] x);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) p = 6'(i);
    end
    return p;
  endfunction

endpackage

/* hdl/pcmf_decode.sv */
// decode stage: byte order, offset and sign-magnitude split of the raw sample
module pcmf_decode import pcmf_pkg::*; (
  input  logic [FmtW-1:0]    fmt_i,
  input  logic [SampleW-1:0] raw_i,
  output prep_t              prep_o
);

  logic [63:0] v;
  logic [31:0] iv;
  logic [5:0]  bm1;
  logic        uns;
  logic        is_int;

  always_comb begin
    v      = '0;
    bm1    = 6'd7;
    uns    = 1'b0;
    is_int = 1'b1;
    prep_o = '0;
    prep_o.kind = KIND_ZERO;
    unique case (fmt_i)
      FMT_S8:    begin v = {56'd0, raw_i[7:0]}; end
      FMT_U8:    begin v = {56'd0, raw_i[7:0]}; uns = 1'b1; end
      FMT_S16LE: begin v = bswap(raw_i, 0) | {48'd0, raw_i[15:0]}; bm1 = 6'd15; end
      FMT_S16BE: begin v = bswap(raw_i, 2); bm1 = 6'd15; end
      FMT_U16LE: begin v = {48'd0, raw_i[15:0]}; bm1 = 6'd15; uns = 1'b1; end
      FMT_U16BE: begin v = bswap(raw_i, 2); bm1 = 6'd15; uns = 1'b1; end
      FMT_S24LE: begin v = {40'd0, raw_i[23:0]}; bm1 = 6'd23; end
      FMT_S24BE: begin v = bswap(raw_i, 3); bm1 = 6'd23; end
      FMT_U24LE: begin v = {40'd0, raw_i[23:0]}; bm1 = 6'd23; uns = 1'b1; end
      FMT_U24BE: begin v = bswap(raw_i, 3); bm1 = 6'd23; uns = 1'b1; end
      FMT_S32LE: begin v = {32'd0, raw_i[31:0]}; bm1 = 6'd31; end
      FMT_S32BE: begin v = bswap(raw_i, 4); bm1 = 6'd31; end
      FMT_U32LE: begin v = {32'd0, raw_i[31:0]}; bm1 = 6'd31; uns = 1'b1; end
      FMT_U32BE: begin v = bswap(raw_i, 4); bm1 = 6'd31; uns = 1'b1; end
      FMT_F32LE: begin v = {32'd0, raw_i[31:0]}; is_int = 1'b0; prep_o.kind = KIND_F32; end
      FMT_F32BE: begin v = bswap(raw_i, 4); is_int = 1'b0; prep_o.kind = KIND_F32; end
      FMT_F64LE: begin v = raw_i; is_int = 1'b0; prep_o.kind = KIND_F64; end
      FMT_F64BE: begin v = bswap(raw_i, 8); is_int = 1'b0; prep_o.kind = KIND_F64; end
      default:   begin is_int = 1'b0; end
    endcase
    iv = v[31:0];
    if (uns) iv[bm1[4:0]] = ~iv[bm1[4:0]];
    // sign-extend to 32 bits
    for (int i = 0; i < 32; i++) begin
      if (6'(i) > bm1) iv[i] = iv[bm1[4:0]];
    end
    prep_o.word    = v;
    prep_o.bits_m1 = bm1;
    if (is_int) begin
      prep_o.kind = KIND_INT;
      prep_o.sign = iv[31];
      prep_o.mag  = iv[31] ? (~iv + 32'd1) : iv;
    end
  end

endmodule

/* hdl/pcmf_round.sv */
// rounding stage: narrows integer and double to single precision, passes f32
module pcmf_round import pcmf_pkg::*; (
  input  prep_t             prep_i,
  output logic [FloatW-1:0] float_o
);

  logic [5:0]  p;
  logic [31:0] norm;
  logic [24:0] im;
  logic        ig, isk;
  logic [7:0]  iexp;
  logic [10:0] de;
  logic [51:0] dm;
  logic [52:0] sig;
  logic [24:0] dq;
  logic [28:0] drem;
  logic        dinc;
  logic signed [12:0] dex;
  logic [7:0]  dsh;
  logic [116:0] sx;
  logic [23:0] sq;
  logic [63:0] srem;
  logic        sinc;
  logic [31:0] dres;

  always_comb begin
    // integer path: normalise so the leading one is at bit 31
    p    = msb_pos(prep_i.mag);
    norm = prep_i.mag << (6'd31 - p);
    ig   = norm[7];
    isk  = |norm[6:0];
    im   = {1'b0, norm[31:8]} + 25'((ig && (isk || norm[8])) ? 1 : 0);
    iexp = 8'(7'd127 + {1'b0, p} - {1'b0, prep_i.bits_m1});
    if (im[24]) iexp = iexp + 8'd1;

    // double path
    de  = prep_i.word[62:52];
    dm  = prep_i.word[51:0];
    sig = (de == 11'd0) ? {1'b0, dm} : {1'b1, dm};
    dex = (de == 11'd0) ? -13'sd1022 : $signed({2'b0, de}) - 13'sd1023;
    drem = sig[28:0];
    dinc = drem[28] && ((|drem[27:0]) || sig[29]);
    dq   = {1'b0, sig[52:29]} + 25'(dinc);
    sx   = '0;
    sq   = '0;
    sinc = 1'b0;
    srem = '0;
    dsh  = 8'd63;
    if (dex > -13'sd160) dsh = 8'(-dex - 13'sd97);
    if (dsh > 8'd63) dsh = 8'd63;
    sx   = {sig, 64'd0} >> dsh;
    srem = sx[63:0];
    sinc = srem[63] && ((|srem[62:0]) || sx[64]);
    sq   = sx[87:64] + 24'(sinc);
    if (de == 11'h7ff) begin
      dres = (dm == 52'd0) ? {prep_i.word[63], 31'h7f800000}
                           : {prep_i.word[63], 31'h7fc00000 | {8'd0, dm[51:29]}};
    end else if (de == 11'd0 && dm == 52'd0) begin
      dres = {prep_i.word[63], 31'd0};
    end else if (dex >= -13'sd126) begin
      logic signed [12:0] e2;
      e2 = dq[24] ? dex + 13'sd1 : dex;
      if (e2 > 13'sd127) dres = {prep_i.word[63], 31'h7f800000};
      else dres = {prep_i.word[63], 8'(e2 + 13'sd127),
                   dq[24] ? dq[23:1] : dq[22:0]};
    end else begin
      dres = {prep_i.word[63], 7'd0, sq};
    end

    unique case (prep_i.kind)
      KIND_INT: float_o = (prep_i.mag == 32'd0) ? 32'd0
                 : {prep_i.sign, iexp, im[24] ? im[23:1] : im[22:0]};
      KIND_F32: float_o = prep_i.word[31:0];
      KIND_F64: float_o = dres;
      default:  float_o = 32'd0;
    endcase
  end

endmodule

/* hdl/pcm_sample_to_float32.sv */
// top level: pcm sample to single-precision float converter
//
// start_i with sample_bytes_i starts a beat; busy_o is always low, so a new
// sample can be taken in every cycle.
// the sample is registered on acceptance, decoded into sign and magnitude,
// registered again, then rounded into the result register.
// done_o is a one-cycle result strobe that follows the accepted sample through
// v0_q, v1_q and v2_q, in step with raw_q, prep_q and res_q; float_bits_o is
// valid for that one cycle.
// throughput: one sample per cycle.
// the receiver cannot stall; every result is shown exactly once.
// sample_format_we_i writes sample_format_i; write only while idle.
// reset clears the strobes and sets the format to signed 16-bit little endian.
module pcm_sample_to_float32 import pcmf_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [SampleW-1:0] sample_bytes_i,
  input  logic               sample_format_we_i,
  input  logic [FmtW-1:0]    sample_format_i,
  output logic               done_o,
  output logic [FloatW-1:0]  float_bits_o
);

  logic [FmtW-1:0]    fmt_q;
  logic               v0_q, v1_q, v2_q;
  logic [SampleW-1:0] raw_q;
  prep_t              prep_d, prep_q;
  logic [FloatW-1:0]  res_d, res_q;

  assign busy_o = 1'b0;

  pcmf_decode u_decode (.fmt_i(fmt_q), .raw_i(raw_q), .prep_o(prep_d));
  pcmf_round  u_round  (.prep_i(prep_q), .float_o(res_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FmtReset;
      v0_q  <= 1'b0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
    end else begin
      if (sample_format_we_i) fmt_q <= sample_format_i;
      v0_q <= start_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q  <= sample_bytes_i;
    prep_q <= prep_d;
    res_q  <= res_d;
  end

  assign done_o       = v2_q;
  assign float_bits_o = res_q;

endmodule
